FILE: hdl/bgr_pkg.sv
// Shared types, codes and reset values for the button gesture recogniser.
package bgr_pkg;

	localparam int unsigned TIME_WIDTH_DEF = 32;
	localparam int unsigned STAMP_WIDTH = 32;
	localparam int unsigned CFG_WIDTH = 16;
	localparam int unsigned CFG_INDEX_WIDTH = 2;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOUBLE_WINDOW = 2'd2;

	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = 16'd20;
	localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST = 16'd500;
	localparam logic [CFG_WIDTH-1:0] DOUBLE_WINDOW_RST = 16'd250;

	localparam logic KIND_CHANGE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_DOWN = 2'd1,
		MODE_PENDING = 2'd2,
		MODE_CONSUMED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		G_PRESS = 2'd0,
		G_DOUBLE = 2'd1,
		G_LONG = 2'd2
	} gesture_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] debounce_ms;
		logic [CFG_WIDTH-1:0] long_press_ms;
		logic [CFG_WIDTH-1:0] double_window_ms;
	} cfg_t;

	typedef struct packed {
		logic valid;
		gesture_t gesture;
	} result_t;

endpackage

FILE: hdl/bgr_cfg.sv
// Configuration register bank for the button gesture recogniser.
module bgr_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bgr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [bgr_pkg::CFG_WIDTH-1:0] cfg_data,
	output bgr_pkg::cfg_t cfg
);

	bgr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= bgr_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ms <= bgr_pkg::LONG_PRESS_RST;
			cfg_q.double_window_ms <= bgr_pkg::DOUBLE_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bgr_pkg::REG_DEBOUNCE: cfg_q.debounce_ms <= cfg_data;
				bgr_pkg::REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data;
				bgr_pkg::REG_DOUBLE_WINDOW: cfg_q.double_window_ms <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/bgr_core.sv
// Gesture state machine: debounce, hold timing and double press window.
module bgr_core #(
	parameter int unsigned TIME_WIDTH = bgr_pkg::TIME_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic kind,
	input  logic pressed,
	input  logic [TIME_WIDTH-1:0] t,
	input  bgr_pkg::cfg_t cfg,
	output bgr_pkg::result_t res
);

	bgr_pkg::mode_t mode_q, mode_d;
	logic level_down_q, level_down_d;
	logic have_last_q, have_last_d;
	logic [TIME_WIDTH-1:0] last_change_q, press_time_q, release_time_q;
	logic upd_change, upd_press, upd_release;

	logic [TIME_WIDTH-1:0] el_press, el_release, el_last;
	logic [TIME_WIDTH-1:0] debounce_w, long_w, window_w;
	logic window_on, bounce;

	assign el_press = t - press_time_q;
	assign el_release = t - release_time_q;
	assign el_last = t - last_change_q;
	assign debounce_w = TIME_WIDTH'(cfg.debounce_ms);
	assign long_w = TIME_WIDTH'(cfg.long_press_ms);
	assign window_w = TIME_WIDTH'(cfg.double_window_ms);
	assign window_on = cfg.double_window_ms != '0;
	assign bounce = have_last_q && (el_last < debounce_w);

	always_comb begin
		mode_d = mode_q;
		level_down_d = level_down_q;
		have_last_d = have_last_q;
		upd_change = 1'b0;
		upd_press = 1'b0;
		upd_release = 1'b0;
		res.valid = 1'b0;
		res.gesture = bgr_pkg::G_PRESS;
		if (step) begin
			if (kind == bgr_pkg::KIND_TICK) begin
				case (mode_q)
					bgr_pkg::MODE_DOWN: begin
						if (el_press >= long_w) begin
							mode_d = bgr_pkg::MODE_CONSUMED;
							res.valid = 1'b1;
							res.gesture = bgr_pkg::G_LONG;
						end
					end
					bgr_pkg::MODE_PENDING: begin
						if (el_release >= window_w) begin
							mode_d = bgr_pkg::MODE_IDLE;
							res.valid = 1'b1;
							res.gesture = bgr_pkg::G_PRESS;
						end
					end
					default: mode_d = mode_q;
				endcase
			end else if (pressed != level_down_q && !bounce) begin
				level_down_d = pressed;
				have_last_d = 1'b1;
				upd_change = 1'b1;
				if (pressed) begin
					if (mode_q == bgr_pkg::MODE_PENDING && window_on) begin
						mode_d = bgr_pkg::MODE_CONSUMED;
						res.valid = 1'b1;
						res.gesture = bgr_pkg::G_DOUBLE;
					end else begin
						upd_press = 1'b1;
						mode_d = bgr_pkg::MODE_DOWN;
					end
				end else if (mode_q == bgr_pkg::MODE_DOWN && window_on) begin
					upd_release = 1'b1;
					mode_d = bgr_pkg::MODE_PENDING;
				end else if (mode_q == bgr_pkg::MODE_DOWN) begin
					mode_d = bgr_pkg::MODE_IDLE;
					res.valid = 1'b1;
					res.gesture = bgr_pkg::G_PRESS;
				end else begin
					mode_d = bgr_pkg::MODE_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bgr_pkg::MODE_IDLE;
			level_down_q <= 1'b0;
			have_last_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			level_down_q <= level_down_d;
			have_last_q <= have_last_d;
		end
	end

	// The time stamps are only read in modes that first write them.
	always_ff @(posedge clk) begin
		if (upd_change) last_change_q <= t;
		if (upd_press) press_time_q <= t;
		if (upd_release) release_time_q <= t;
	end

	a_res_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> step)
		else $error("result raised without an input beat");

	a_double_consumes: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.gesture == bgr_pkg::G_DOUBLE) |=> mode_q == bgr_pkg::MODE_CONSUMED)
		else $error("double press did not consume the hold");

	a_release_leaves_down: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(level_down_q) |-> mode_q != bgr_pkg::MODE_DOWN)
		else $error("release left the mode at down");

	a_press_holds: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(level_down_q) |-> (mode_q == bgr_pkg::MODE_DOWN ||
			mode_q == bgr_pkg::MODE_CONSUMED))
		else $error("press did not enter a held mode");

endmodule

FILE: hdl/button_gesture_recognizer.sv
// Top level of the button gesture recogniser: input stage, core and result register.
//
// Input channel (in_valid/in_ready) carries one beat per event: kind selects a
// level change or a time tick, pressed gives the new level, time_ms the stamp.
// Output channel (out_valid/out_ready) carries one beat per recognised
// gesture: press, double press or long press. An event gives at most one beat.
// An accepted event is held in the input stage register; the core then decides in
// a single pass and, once the result register is free, loads it, so a gesture is
// offered from the result register after its event beat is accepted.
// Throughput is one event per cycle, limited only by the result register.
// While a result waits unaccepted, the input stage holds its event and in_ready
// falls once that stage is occupied; both move on at the edge at which
// out_ready takes the waiting result.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it while the block is idle, which the block itself does not enforce; unknown indexes are ignored.
// Reset (arst_n low) empties both stages, returns the gesture logic to idle
// with the button released and no change seen, and restores the default
// debounce, long press and double window times.
module button_gesture_recognizer #(
	parameter int unsigned TIME_WIDTH = bgr_pkg::TIME_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic kind,
	input  logic pressed,
	input  logic [bgr_pkg::STAMP_WIDTH-1:0] time_ms,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] gesture,
	input  logic cfg_we,
	input  logic [bgr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [bgr_pkg::CFG_WIDTH-1:0] cfg_data
);

	bgr_pkg::cfg_t cfg;
	bgr_pkg::result_t res;

	logic valid_s1;
	logic kind_s1, pressed_s1;
	logic [TIME_WIDTH-1:0] time_s1;
	logic out_valid_q;
	bgr_pkg::gesture_t gesture_q;
	logic out_free, step;

	assign out_free = !out_valid_q || out_ready;
	assign step = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			pressed_s1 <= pressed;
			time_s1 <= TIME_WIDTH'(time_ms);
		end
	end

	bgr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	bgr_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.kind(kind_s1),
		.pressed(pressed_s1),
		.t(time_s1),
		.cfg(cfg),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			gesture_q <= res.gesture;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture = gesture_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input held back without a stalled result");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> valid_s1 && $stable(time_s1))
		else $error("input stage lost a held beat");

	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !step) |=> !out_valid_q)
		else $error("result register loaded without a core step");

endmodule

FILE: verif/button_gesture_recognizer_test.sv
// Self-checking testbench for the button gesture recogniser with a random beat driver and monitor.
module button_gesture_recognizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS = 200;
	localparam int unsigned PHASES = 9;
	localparam logic [bgr_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic kind;
		logic pressed;
		logic [bgr_pkg::STAMP_WIDTH-1:0] stamp;
	} btn_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = bgr_pkg::KIND_CHANGE;
	logic pressed = 1'b0;
	logic [bgr_pkg::STAMP_WIDTH-1:0] time_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] gesture;
	logic cfg_we = 1'b0;
	logic [bgr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = bgr_pkg::REG_DEBOUNCE;
	logic [bgr_pkg::CFG_WIDTH-1:0] cfg_data = '0;

	button_gesture_recognizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.pressed(pressed),
		.time_ms(time_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gesture(gesture),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	btn_beat_t stim_beats[$];
	bgr_pkg::gesture_t expected_gestures[$];
	int unsigned beats_in_flight = 0;
	int unsigned errors = 0;
	bit steady = 1'b0;

	logic [bgr_pkg::CFG_WIDTH-1:0] cfg_debounce = bgr_pkg::DEBOUNCE_RST;
	logic [bgr_pkg::CFG_WIDTH-1:0] cfg_long = bgr_pkg::LONG_PRESS_RST;
	logic [bgr_pkg::CFG_WIDTH-1:0] cfg_window = bgr_pkg::DOUBLE_WINDOW_RST;

	bgr_pkg::mode_t mode_q = bgr_pkg::MODE_IDLE;
	logic level_q = 1'b0;
	logic seen_change = 1'b0;
	logic [bgr_pkg::STAMP_WIDTH-1:0] last_change_at = '0;
	logic [bgr_pkg::STAMP_WIDTH-1:0] press_at = '0;
	logic [bgr_pkg::STAMP_WIDTH-1:0] release_at = '0;

	logic [bgr_pkg::STAMP_WIDTH-1:0] now_ms;
	logic [bgr_pkg::STAMP_WIDTH-1:0] gen_press_at = '0;
	logic [bgr_pkg::STAMP_WIDTH-1:0] gen_release_at = '0;
	logic gen_level = 1'b0;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic note_gesture(input bgr_pkg::gesture_t g);
		expected_gestures.insert(expected_gestures.size(), g);
	endtask

	task automatic recognise_gesture(input btn_beat_t b);
		logic [bgr_pkg::STAMP_WIDTH-1:0] since_press;
		logic [bgr_pkg::STAMP_WIDTH-1:0] since_release;
		logic [bgr_pkg::STAMP_WIDTH-1:0] since_change;
		since_press = b.stamp - press_at;
		since_release = b.stamp - release_at;
		since_change = b.stamp - last_change_at;
		if (b.kind == bgr_pkg::KIND_TICK) begin
			if (mode_q == bgr_pkg::MODE_DOWN && since_press >= {16'd0, cfg_long}) begin
				mode_q = bgr_pkg::MODE_CONSUMED;
				note_gesture(bgr_pkg::G_LONG);
			end else if (mode_q == bgr_pkg::MODE_PENDING &&
					since_release >= {16'd0, cfg_window}) begin
				mode_q = bgr_pkg::MODE_IDLE;
				note_gesture(bgr_pkg::G_PRESS);
			end
		end else if (b.pressed != level_q &&
				!(seen_change && since_change < {16'd0, cfg_debounce})) begin
			level_q = b.pressed;
			seen_change = 1'b1;
			last_change_at = b.stamp;
			if (b.pressed) begin
				if (mode_q == bgr_pkg::MODE_PENDING && cfg_window != 0) begin
					mode_q = bgr_pkg::MODE_CONSUMED;
					note_gesture(bgr_pkg::G_DOUBLE);
				end else begin
					press_at = b.stamp;
					mode_q = bgr_pkg::MODE_DOWN;
				end
			end else if (mode_q == bgr_pkg::MODE_DOWN && cfg_window != 0) begin
				release_at = b.stamp;
				mode_q = bgr_pkg::MODE_PENDING;
			end else if (mode_q == bgr_pkg::MODE_DOWN) begin
				mode_q = bgr_pkg::MODE_IDLE;
				note_gesture(bgr_pkg::G_PRESS);
			end else begin
				mode_q = bgr_pkg::MODE_IDLE;
			end
		end
	endtask

	// Driver: holds each beat until accepted, then waits out a random gap.
	int unsigned in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		btn_beat_t b;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				recognise_gesture('{kind: kind, pressed: pressed, stamp: time_ms});
				beats_in_flight--;
			end
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (stim_beats.size() != 0) begin
					b = stim_beats.pop_front();
					kind <= b.kind;
					pressed <= b.pressed;
					time_ms <= b.stamp;
					in_valid <= 1'b1;
					in_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat against the oldest expectation.
	int unsigned out_stall = 0;
	always @(posedge clk or negedge arst_n) begin
		bgr_pkg::gesture_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_gestures.size() == 0) begin
					$error("gesture: expected none, actual %0d", gesture);
					errors++;
				end else begin
					want = expected_gestures.pop_front();
					if (gesture !== want) begin
						$error("gesture: expected %0d, actual %0d", want, gesture);
						errors++;
					end
				end
				out_stall = pick_gap();
			end else if (out_stall == 0 && $urandom_range(0, 15) == 0) begin
				out_stall = pick_gap();
			end
			if (out_stall != 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else if (beats_in_flight != 0 || expected_gestures.size() != 0)
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic queue_beat(input logic k, input logic p,
			input logic [bgr_pkg::STAMP_WIDTH-1:0] t);
		btn_beat_t nb;
		nb = '{kind: k, pressed: p, stamp: t};
		stim_beats.insert(stim_beats.size(), nb);
		beats_in_flight++;
	endtask

	task automatic wait_drained();
		while (beats_in_flight != 0 || expected_gestures.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bgr_pkg::CFG_INDEX_WIDTH-1:0] idx,
			input logic [bgr_pkg::CFG_WIDTH-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			bgr_pkg::REG_DEBOUNCE: cfg_debounce = val;
			bgr_pkg::REG_LONG_PRESS: cfg_long = val;
			bgr_pkg::REG_DOUBLE_WINDOW: cfg_window = val;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(input logic [bgr_pkg::CFG_WIDTH-1:0] deb,
			input logic [bgr_pkg::CFG_WIDTH-1:0] lng,
			input logic [bgr_pkg::CFG_WIDTH-1:0] win);
		wait_drained();
		write_reg(bgr_pkg::REG_DEBOUNCE, deb);
		write_reg(bgr_pkg::REG_LONG_PRESS, lng);
		write_reg(bgr_pkg::REG_DOUBLE_WINDOW, win);
		end_writes();
	endtask

	task automatic gen_random(input int unsigned count);
		int unsigned r;
		int unsigned deb;
		int unsigned lng;
		int unsigned win;
		logic [bgr_pkg::STAMP_WIDTH-1:0] t;
		deb = 32'(cfg_debounce);
		lng = 32'(cfg_long);
		win = 32'(cfg_window);
		now_ms = $urandom;
		for (int unsigned n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				case ($urandom_range(0, 3))
					0: t = now_ms + $urandom_range(0, deb + deb / 2 + 1);
					1: t = now_ms + deb + $urandom_range(0, win + 10);
					2: t = now_ms + deb + $urandom_range(0, lng * 2 + 10);
					default: t = now_ms + deb + $urandom_range(0, 2) - 1;
				endcase
				gen_level = ~gen_level;
				if (gen_level)
					gen_press_at = t;
				else
					gen_release_at = t;
				now_ms = t;
				queue_beat(bgr_pkg::KIND_CHANGE, gen_level, t);
			end else if (r < 88) begin
				case ($urandom_range(0, 4))
					0, 1, 2: begin
						t = now_ms + $urandom_range(0, lng + win + 20);
						now_ms = t;
					end
					3: t = gen_press_at + lng + $urandom_range(0, 1) - 1;
					default: t = gen_release_at + win + $urandom_range(0, 1) - 1;
				endcase
				queue_beat(bgr_pkg::KIND_TICK, 1'($urandom_range(0, 1)), t);
			end else if (r < 95) begin
				now_ms = now_ms + $urandom_range(0, deb + 5);
				queue_beat(bgr_pkg::KIND_CHANGE, gen_level, now_ms);
			end else begin
				now_ms = $urandom;
				queue_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), now_ms);
			end
		end
	endtask

	initial begin
		logic [bgr_pkg::STAMP_WIDTH-1:0] t0;
		logic [bgr_pkg::CFG_WIDTH-1:0] deb;
		logic [bgr_pkg::CFG_WIDTH-1:0] lng;
		logic [bgr_pkg::CFG_WIDTH-1:0] win;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sequence at the reset settings, starting just short of the wrap point.
		t0 = 32'hFFFF_FF00;
		queue_beat(bgr_pkg::KIND_TICK, 1'b1, t0);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b1, t0);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0 + 10);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0 + 20);
		queue_beat(bgr_pkg::KIND_TICK, 1'b0, t0 + 269);
		queue_beat(bgr_pkg::KIND_TICK, 1'b1, t0 + 270);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b1, t0 + 300);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0 + 350);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b1, t0 + 400);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0 + 450);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b1, t0 + 500);
		queue_beat(bgr_pkg::KIND_TICK, 1'b0, t0 + 999);
		queue_beat(bgr_pkg::KIND_TICK, 1'b0, t0 + 1000);
		queue_beat(bgr_pkg::KIND_TICK, 1'b1, t0 + 1100);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0 + 1200);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b1, t0 + 1300);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0 + 1350);

		// The window is cleared while a press is still withheld.
		wait_drained();
		write_reg(bgr_pkg::REG_DOUBLE_WINDOW, 16'd0);
		end_writes();
		queue_beat(bgr_pkg::KIND_TICK, 1'b0, t0 + 1351);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b1, t0 + 1400);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0 + 1450);
		wait_drained();
		write_reg(bgr_pkg::REG_DOUBLE_WINDOW, bgr_pkg::DOUBLE_WINDOW_RST);
		end_writes();
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b1, t0 + 1500);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0 + 1550);
		wait_drained();
		write_reg(bgr_pkg::REG_DOUBLE_WINDOW, 16'd0);
		end_writes();
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b1, t0 + 1600);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0 + 1650);

		// Zero thresholds, with a write to the unused index in between.
		wait_drained();
		write_reg(bgr_pkg::REG_DEBOUNCE, 16'd0);
		write_reg(REG_SPARE, 16'hFFFF);
		write_reg(bgr_pkg::REG_LONG_PRESS, 16'd0);
		end_writes();
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b1, t0 + 1650);
		queue_beat(bgr_pkg::KIND_TICK, 1'b1, t0 + 1650);
		queue_beat(bgr_pkg::KIND_CHANGE, 1'b0, t0 + 1650);

		for (int unsigned p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					deb = bgr_pkg::DEBOUNCE_RST;
					lng = bgr_pkg::LONG_PRESS_RST;
					win = bgr_pkg::DOUBLE_WINDOW_RST;
				end
				1: begin deb = 16'd0; lng = 16'd0; win = 16'd0; end
				2: begin deb = 16'hFFFF; lng = 16'hFFFF; win = 16'hFFFF; end
				3: begin deb = 16'd0; lng = 16'd300; win = 16'hFFFF; end
				4: begin deb = 16'hFFFF; lng = 16'd0; win = 16'd0; end
				default: begin
					deb = 16'($urandom_range(0, 40));
					lng = 16'($urandom_range(0, 600));
					win = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 300));
				end
			endcase
			apply_settings(deb, lng, win);
			steady = (p % 4 == 3);
			gen_random(PHASE_ITEMS);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
